// ----- rtl/obb_sat_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Widths, product indexes and rounding helpers for the box overlap pipeline.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

  localparam int unsigned NumAxes = 15;
  localparam int unsigned NumProd = 9;
  localparam int unsigned MatW    = 36;

  // quaternion product slots
  localparam int unsigned PXX = 0;
  localparam int unsigned PYY = 1;
  localparam int unsigned PZZ = 2;
  localparam int unsigned PXY = 3;
  localparam int unsigned PXZ = 4;
  localparam int unsigned PYZ = 5;
  localparam int unsigned PWX = 6;
  localparam int unsigned PWY = 7;
  localparam int unsigned PWZ = 8;

  localparam logic signed [MatW-1:0] OneQ28 = MatW'(64'sd268435456);
  localparam logic signed [15:0]     UnitQ14 = 16'sd16384;

  // Q.28 matrix entry to Q2.14, round half up, clamped to +-1.0
  function automatic logic signed [15:0] axis_entry(input logic signed [MatW-1:0] m);
    logic signed [MatW-1:0] r;
    logic signed [15:0]     res;
    r = (m + MatW'(8192)) >>> 14;
    if (r > MatW'(UnitQ14)) begin
      res = UnitQ14;
    end else if (r < -MatW'(UnitQ14)) begin
      res = -UnitQ14;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  // Q.28 cross component to Q.14, round half up
  function automatic logic signed [16:0] cross_round(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    return r[16:0];
  endfunction

endpackage

// ----- rtl/oriented_box_overlap_sat_top.sv -----
// ----------------------------------------------------------------------------
// oriented_box_overlap_sat_top
// 15-axis separating axis overlap test of a box against a stored reference.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | valid_i / stall_o  | opcode, center, quat, half
//  result  | out       | valid_o / stall_i  | overlap
//
// Seven register stages: quaternion products, axis rounding, cross axes,
// dot products, extent products, projection sum, compare. One transaction
// per cycle while the result channel is not stalled.
// Store transactions update the reference at once and travel as bubbles.
// Reset loads the identity reference box with zero centre and extents.
// A stalled result freezes every stage together.
module oriented_box_overlap_sat_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               opcode_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic        [30:0] half_x_i,
  input  logic        [30:0] half_y_i,
  input  logic        [30:0] half_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               overlap_o
);

  localparam int unsigned NA = obb_sat_pkg::NumAxes;
  localparam int unsigned NP = obb_sat_pkg::NumProd;
  localparam int unsigned MW = obb_sat_pkg::MatW;

  logic en, acc;
  logic out_valid_q, overlap_q;

  assign stall_o = out_valid_q & stall_i;
  assign en      = ~stall_o;
  assign acc     = valid_i & en;

  // reference box
  logic signed [31:0] ref_c_q [3];
  logic signed [15:0] ref_q_q [4];
  logic        [30:0] ref_h_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ref_c_q[i] <= '0;
        ref_h_q[i] <= '0;
      end
      ref_q_q[0] <= obb_sat_pkg::UnitQ14;
      ref_q_q[1] <= '0;
      ref_q_q[2] <= '0;
      ref_q_q[3] <= '0;
    end else if (acc && !opcode_i) begin
      ref_c_q[0] <= center_x_i;
      ref_c_q[1] <= center_y_i;
      ref_c_q[2] <= center_z_i;
      ref_q_q[0] <= quat_w_i;
      ref_q_q[1] <= quat_x_i;
      ref_q_q[2] <= quat_y_i;
      ref_q_q[3] <= quat_z_i;
      ref_h_q[0] <= half_x_i;
      ref_h_q[1] <= half_y_i;
      ref_h_q[2] <= half_z_i;
    end
  end

  // stage valids
  logic [6:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[5:1], acc & opcode_i};
      out_valid_q <= v_q[6];
    end
  end

  // half extents travel with the transaction (box 0 = reference, 1 = test)
  logic [30:0] h1_q [2][3], h2_q [2][3], h3_q [2][3], h4_q [2][3];

  // ---------------- stage 1: quaternion products, centre difference
  logic signed [15:0] qin [2][4];
  logic signed [31:0] p_d [2][NP], p1_q [2][NP];
  logic signed [32:0] d_d [3], d1_q [3], d2_q [3], d3_q [3];

  always_comb begin
    qin[0] = ref_q_q;
    qin[1][0] = quat_w_i;
    qin[1][1] = quat_x_i;
    qin[1][2] = quat_y_i;
    qin[1][3] = quat_z_i;
    for (int b = 0; b < 2; b++) begin
      p_d[b][obb_sat_pkg::PXX] = qin[b][1] * qin[b][1];
      p_d[b][obb_sat_pkg::PYY] = qin[b][2] * qin[b][2];
      p_d[b][obb_sat_pkg::PZZ] = qin[b][3] * qin[b][3];
      p_d[b][obb_sat_pkg::PXY] = qin[b][1] * qin[b][2];
      p_d[b][obb_sat_pkg::PXZ] = qin[b][1] * qin[b][3];
      p_d[b][obb_sat_pkg::PYZ] = qin[b][2] * qin[b][3];
      p_d[b][obb_sat_pkg::PWX] = qin[b][0] * qin[b][1];
      p_d[b][obb_sat_pkg::PWY] = qin[b][0] * qin[b][2];
      p_d[b][obb_sat_pkg::PWZ] = qin[b][0] * qin[b][3];
    end
    d_d[0] = 33'(ref_c_q[0]) - 33'(center_x_i);
    d_d[1] = 33'(ref_c_q[1]) - 33'(center_y_i);
    d_d[2] = 33'(ref_c_q[2]) - 33'(center_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q     <= p_d;
      d1_q     <= d_d;
      h1_q[0]  <= ref_h_q;
      h1_q[1][0] <= half_x_i;
      h1_q[1][1] <= half_y_i;
      h1_q[1][2] <= half_z_i;
    end
  end

  // ---------------- stage 2: rotation matrices, rounded to Q2.14
  logic signed [MW-1:0] p [NP];
  logic signed [15:0]   ax_d [2][3][3], ax2_q [2][3][3];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int n = 0; n < NP; n++) p[n] = MW'(p1_q[b][n]);
      ax_d[b][0][0] = obb_sat_pkg::axis_entry(obb_sat_pkg::OneQ28 -
        2 * (p[obb_sat_pkg::PYY] + p[obb_sat_pkg::PZZ]));
      ax_d[b][0][1] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PXY] + p[obb_sat_pkg::PWZ]));
      ax_d[b][0][2] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PXZ] - p[obb_sat_pkg::PWY]));
      ax_d[b][1][0] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PXY] - p[obb_sat_pkg::PWZ]));
      ax_d[b][1][1] = obb_sat_pkg::axis_entry(obb_sat_pkg::OneQ28 -
        2 * (p[obb_sat_pkg::PXX] + p[obb_sat_pkg::PZZ]));
      ax_d[b][1][2] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PYZ] + p[obb_sat_pkg::PWX]));
      ax_d[b][2][0] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PXZ] + p[obb_sat_pkg::PWY]));
      ax_d[b][2][1] = obb_sat_pkg::axis_entry(2 * (p[obb_sat_pkg::PYZ] - p[obb_sat_pkg::PWX]));
      ax_d[b][2][2] = obb_sat_pkg::axis_entry(obb_sat_pkg::OneQ28 -
        2 * (p[obb_sat_pkg::PXX] + p[obb_sat_pkg::PYY]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q <= ax_d;
      d2_q  <= d1_q;
      h2_q  <= h1_q;
    end
  end

  // ---------------- stage 3: candidate axes (faces, then edge crosses)
  logic signed [16:0] l_d [NA][3], l3_q [NA][3];
  logic signed [15:0] ax3_q [2][3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        l_d[i][j]     = 17'(ax2_q[0][i][j]);
        l_d[3 + i][j] = 17'(ax2_q[1][i][j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          l_d[6 + 3 * i + j][c] = obb_sat_pkg::cross_round(
            34'(ax2_q[0][i][(c + 1) % 3]) * 34'(ax2_q[1][j][(c + 2) % 3]) -
            34'(ax2_q[0][i][(c + 2) % 3]) * 34'(ax2_q[1][j][(c + 1) % 3]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l3_q  <= l_d;
      ax3_q <= ax2_q;
      d3_q  <= d2_q;
      h3_q  <= h2_q;
    end
  end

  // ---------------- stage 4: centre and box axis projections
  logic signed [51:0] dl;
  logic signed [34:0] pr;
  logic        [49:0] dm_d [NA], dm4_q [NA];
  logic        [30:0] pm_d [NA][2][3], pm4_q [NA][2][3];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      dl = 52'(d3_q[0]) * 52'(l3_q[k][0]) + 52'(d3_q[1]) * 52'(l3_q[k][1]) +
           52'(d3_q[2]) * 52'(l3_q[k][2]);
      dm_d[k] = dl[51] ? 50'(-dl) : dl[49:0];
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 3; i++) begin
          pr = 35'(ax3_q[b][i][0]) * 35'(l3_q[k][0]) +
               35'(ax3_q[b][i][1]) * 35'(l3_q[k][1]) +
               35'(ax3_q[b][i][2]) * 35'(l3_q[k][2]);
          pm_d[k][b][i] = pr[34] ? 31'(-pr) : pr[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm4_q <= dm_d;
      pm4_q <= pm_d;
      h4_q  <= h3_q;
    end
  end

  // ---------------- stage 5: extent times projection
  logic [61:0] t_d [NA][6], t5_q [NA][6];
  logic [49:0] dm5_q [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 3; i++) begin
          t_d[k][3 * b + i] = 62'(h4_q[b][i]) * 62'(pm4_q[k][b][i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_q  <= t_d;
      dm5_q <= dm4_q;
    end
  end

  // ---------------- stage 6: radius sum
  logic [64:0] s_d [NA], s6_q [NA];
  logic [49:0] dm6_q [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      s_d[k] = 65'(t5_q[k][0]) + 65'(t5_q[k][1]) + 65'(t5_q[k][2]) +
               65'(t5_q[k][3]) + 65'(t5_q[k][4]) + 65'(t5_q[k][5]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q  <= s_d;
      dm6_q <= dm5_q;
    end
  end

  // ---------------- stage 7: separation compare
  logic [NA-1:0] sep;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      sep[k] = {1'b0, dm6_q[k], 14'b0} > s6_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      overlap_q <= ~|sep;
    end
  end

  assign valid_o   = out_valid_q;
  assign overlap_o = overlap_q;

endmodule
